// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the altimeter filter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/aslf_pkg.sv
// ---------------------------------------------------------------------------
// aslf_pkg
// Types and constants for the altimeter slew-limited low-pass filter.
// ---------------------------------------------------------------------------
`default_nettype none

package aslf_pkg;

  localparam int unsigned HeightW = 24;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HeightW-1:0] HeightInit = 24'd6554;
  localparam logic [CfgW-1:0]    MaxStepRst = 16'd546;
  localparam logic [CfgW-1:0]    LpfGainRst = 16'd11349;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_STEP        = 2'd0,
    CFG_LPF_GAIN        = 2'd1,
    CFG_OUTPUT_FILTERED = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

  typedef struct packed {
    logic               req_type;
    logic [HeightW-1:0] range_value;
    logic               range_inf;
    logic               range_nan;
  } in_item_t;

  typedef struct packed {
    logic [HeightW-1:0] height_out;
    logic [HeightW-1:0] raw_height;
    logic [HeightW-1:0] limited_height;
    logic [HeightW-1:0] smoothed_height;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] max_step;
    logic [CfgW-1:0] lpf_gain;
    logic            output_filtered;
  } cfg_t;

  typedef struct packed {
    logic [HeightW-1:0] measured;
    logic [HeightW-1:0] slewed;
    logic [HeightW-1:0] lowpass;
  } heights_t;

endpackage

`default_nettype wire

// File: rtl/altimeter_slew_lowpass_filter_top.sv
// ---------------------------------------------------------------------------
// altimeter_slew_lowpass_filter_top
// Conditions a rangefinder height: sample transfers update the measured
// height, tick transfers return slew-limited and low-pass filtered heights.
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid_i / in_ready_o          input      in_item_t
//   out      out_valid_o / out_ready_i        output     out_item_t
//   cfg      cfg_we_i / cfg_idx_i             input      cfg_wdata_i
//
// An item is processed while it sits in the input register, and a tick
// result is then held in the result register, so a result passes both
// registers before its transfer. One item per cycle is sustained while no
// tick stalls; samples give no result. The input register refills while a
// result waits, and a tick stalls there only while the result register is
// full and not taken.
// Reset loads 0.1 m into all heights and the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module altimeter_slew_lowpass_filter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [aslf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [aslf_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  aslf_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output aslf_pkg::out_item_t          out_data_o
);
  import aslf_pkg::*;

  cfg_t      cfg_q;
  heights_t  hgt_q, hgt_d, tick_nxt;
  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res_q;
  logic      res_vld_q;
  logic      is_tick;
  logic      res_free;
  logic      proc;
  logic      take_in;

  aslf_calc u_calc (
    .cfg_i (cfg_q),
    .cur_i (hgt_q),
    .nxt_o (tick_nxt)
  );

  assign is_tick    = (item_q.req_type == REQ_TICK);
  assign res_free   = !res_vld_q || out_ready_i;
  assign proc       = item_vld_q && (!is_tick || res_free);
  assign in_ready_o = !item_vld_q || proc;
  assign take_in    = in_valid_i && in_ready_o;

  always_comb begin
    hgt_d = hgt_q;
    if (proc) begin
      if (is_tick) begin
        hgt_d = tick_nxt;
      end else if (item_q.range_nan) begin
        hgt_d.measured = hgt_q.measured;
      end else if (item_q.range_inf) begin
        hgt_d.measured = HeightInit;
      end else begin
        hgt_d.measured = item_q.range_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_step        <= MaxStepRst;
      cfg_q.lpf_gain        <= LpfGainRst;
      cfg_q.output_filtered <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_STEP:        cfg_q.max_step        <= cfg_wdata_i;
        CFG_LPF_GAIN:        cfg_q.lpf_gain        <= cfg_wdata_i;
        CFG_OUTPUT_FILTERED: cfg_q.output_filtered <= cfg_wdata_i[0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hgt_q.measured <= HeightInit;
      hgt_q.slewed   <= HeightInit;
      hgt_q.lowpass  <= HeightInit;
      item_vld_q     <= 1'b0;
      res_vld_q      <= 1'b0;
    end else begin
      hgt_q <= hgt_d;
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (proc && is_tick) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q <= in_data_i;
    end
    if (proc && is_tick) begin
      res_q.height_out      <= cfg_q.output_filtered ? tick_nxt.lowpass : tick_nxt.measured;
      res_q.raw_height      <= tick_nxt.measured;
      res_q.limited_height  <= tick_nxt.slewed;
      res_q.smoothed_height <= tick_nxt.lowpass;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// File: rtl/aslf_calc.sv
// ---------------------------------------------------------------------------
// aslf_calc
// Tick update: slew-rate limit toward the measured height, then a rounded
// first-order low-pass blend toward the limited height.
// ---------------------------------------------------------------------------
`default_nettype none

module aslf_calc (
  input  aslf_pkg::cfg_t     cfg_i,
  input  aslf_pkg::heights_t cur_i,
  output aslf_pkg::heights_t nxt_o
);
  import aslf_pkg::*;

  logic               up;
  logic [HeightW-1:0] gap;
  logic [HeightW-1:0] step;
  logic [HeightW-1:0] slew_nxt;
  logic signed [HeightW:0]     diff;
  logic signed [HeightW+17:0]  prod;
  logic signed [HeightW+17:0]  prod_rnd;
  logic signed [HeightW+1:0]   q;
  logic signed [HeightW+2:0]   sum;
  logic [HeightW-1:0] lp_nxt;

  always_comb begin
    step = {{(HeightW-CfgW){1'b0}}, cfg_i.max_step};
    up   = (cur_i.measured >= cur_i.slewed);
    gap  = up ? (cur_i.measured - cur_i.slewed) : (cur_i.slewed - cur_i.measured);
    if (gap > step) begin
      slew_nxt = up ? (cur_i.slewed + step) : (cur_i.slewed - step);
    end else begin
      slew_nxt = cur_i.measured;
    end
  end

  always_comb begin
    diff     = $signed({1'b0, slew_nxt}) - $signed({1'b0, cur_i.lowpass});
    prod     = diff * $signed({1'b0, cfg_i.lpf_gain});
    prod_rnd = prod + 42'sd32768;
    q        = prod_rnd[HeightW+17:16];
    sum      = $signed({3'b000, cur_i.lowpass}) + $signed({q[HeightW+1], q});
    if (sum[HeightW+2]) begin
      lp_nxt = '0;
    end else if (sum[HeightW+1:HeightW] != 2'b00) begin
      lp_nxt = '1;
    end else begin
      lp_nxt = sum[HeightW-1:0];
    end
  end

  assign nxt_o.measured = cur_i.measured;
  assign nxt_o.slewed   = slew_nxt;
  assign nxt_o.lowpass  = lp_nxt;

endmodule

`default_nettype wire

// File: rtl/aslf_checker.sv
// ---------------------------------------------------------------------------
// aslf_checker
// Port-level checks on the altimeter filter, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aslf_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_ready_o,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire aslf_pkg::out_item_t    out_data_o
);

  `ASLF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `ASLF_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o),
               "result changed while stalled")
  `ASLF_ASSERT(a_sel_height, out_valid_o |-> (out_data_o.height_out == out_data_o.raw_height) ||
               (out_data_o.height_out == out_data_o.smoothed_height),
               "selected height matches neither source")
  `ASLF_ASSERT(a_in_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without cause")
  `ASLF_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind altimeter_slew_lowpass_filter_top aslf_checker u_aslf_checker (.*);

`default_nettype wire
